[hw/rtl/jfhp_pkg.sv]
// Types and constants shared by the frame header parser.
package jfhp_pkg;

    localparam int unsigned FIXED_HDR_BYTES = 8;
    localparam int unsigned FIFO_DEPTH      = 4;

    typedef enum logic [2:0] {
        ST_RECORD    = 3'd0,
        ST_FRAME_OK  = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_LARGE_ID  = 3'd3,
        ST_BAD_H     = 3'd4,
        ST_BAD_V     = 3'd5,
        ST_BAD_SIZE  = 3'd6
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  quant_table;
        logic [3:0]  v_factor;
        logic [3:0]  h_factor;
        logic [7:0]  component_id;
        logic [3:0]  max_v;
        logic [3:0]  max_h;
        logic [7:0]  component_count;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  precision;
    } rec_t;

    function automatic logic factor_ok(input logic [3:0] f);
        return (f == 4'd1) || (f == 4'd2) || (f == 4'd4);
    endfunction

endpackage

[hw/rtl/jpeg_frame_header_parser.sv]
// Baseline JPEG frame header parser: byte stream in, component and frame records out.
//
//  channel  | dir | tdata                          | tuser       | tlast
//  s_axis   | in  | data_byte                      | seg. start  | segment end
//  m_axis   | out | frame and component fields     | status      | -
//
//  One header byte is taken per clock while s_axis_tready is high; its records
//  (zero, one or two) are written to a four-entry output queue in the same cycle.
//  Records leave at one per clock while m_axis_tready is high; s_axis_tready
//  drops only while fewer than two queue entries are free.
//  Reset leaves the parser halted, waiting for a byte with tuser set.
module jpeg_frame_header_parser
    import jfhp_pkg::*;
#(
    parameter int MAX_COMPONENTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] segment_start
    input  logic        s_axis_tlast,   // segment_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] precision, [23:8] height, [39:24] width, [47:40] component_count,
    // [51:48] max_h, [55:52] max_v, [63:56] component_id, [67:64] h_factor,
    // [71:68] v_factor, [79:72] quant_table
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    // parser state
    logic [4:0]  pos_reg,    pos_next;
    logic [1:0]  phase_reg,  phase_next;
    logic [15:0] len_reg,    len_next;
    logic [7:0]  prec_reg,   prec_next;
    logic [15:0] hgt_reg,    hgt_next;
    logic [15:0] wid_reg,    wid_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [2:0]  done_reg,   done_next;
    logic [7:0]  id_reg,     id_next;
    logic [3:0]  h_reg,      h_next;
    logic [3:0]  v_reg,      v_next;
    logic [3:0]  mh_reg,     mh_next;
    logic [3:0]  mv_reg,     mv_next;
    logic        halted_reg, halted_next;

    // output queue
    rec_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;

    logic       in_fire, out_fire;
    logic [1:0] push_n;
    rec_t       res0, res1;
    logic [7:0] b;
    logic [2:0] done_inc;
    logic [15:0] expect_len;

    function automatic rec_t make_rec(
        input status_t     st,
        input logic [7:0]  prec,
        input logic [15:0] hgt,
        input logic [15:0] wid,
        input logic [7:0]  cnt,
        input logic [3:0]  mh,
        input logic [3:0]  mv,
        input logic [7:0]  id,
        input logic [3:0]  h,
        input logic [3:0]  v,
        input logic [7:0]  q
    );
        rec_t r;
        r.status          = st;
        r.precision       = prec;
        r.height          = hgt;
        r.width           = wid;
        r.component_count = cnt;
        r.max_h           = mh;
        r.max_v           = mv;
        r.component_id    = id;
        r.h_factor        = h;
        r.v_factor        = v;
        r.quant_table     = q;
        return r;
    endfunction

    assign b             = s_axis_tdata;
    assign s_axis_tready = (fill_reg <= (PTR_W+1)'(FIFO_DEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (fill_reg != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        logic adv;
        logic start;
        adv   = 1'b0;
        start = s_axis_tuser;

        pos_next    = start ? '0 : pos_reg;
        phase_next  = start ? '0 : phase_reg;
        len_next    = start ? '0 : len_reg;
        prec_next   = start ? '0 : prec_reg;
        hgt_next    = start ? '0 : hgt_reg;
        wid_next    = start ? '0 : wid_reg;
        cnt_next    = start ? '0 : cnt_reg;
        done_next   = start ? '0 : done_reg;
        id_next     = start ? '0 : id_reg;
        h_next      = start ? '0 : h_reg;
        v_next      = start ? '0 : v_reg;
        mh_next     = start ? '0 : mh_reg;
        mv_next     = start ? '0 : mv_reg;
        halted_next = start ? 1'b0 : halted_reg;

        push_n     = 2'd0;
        res0       = '0;
        res1       = '0;
        done_inc   = done_next + 3'd1;
        expect_len = 16'(FIXED_HDR_BYTES) + {12'd0, cnt_next, 1'b0} + {13'd0, cnt_next};

        if (!halted_next)
        begin
            adv = 1'b1;
            if (pos_next < 5'(FIXED_HDR_BYTES))
            begin
                unique case (pos_next[2:0])
                    3'd0: len_next = {b, 8'd0};
                    3'd1: len_next = {len_next[15:8], b};
                    3'd2: prec_next = b;
                    3'd3: hgt_next = {b, 8'd0};
                    3'd4: hgt_next = {hgt_next[15:8], b};
                    3'd5: wid_next = {b, 8'd0};
                    3'd6: wid_next = {wid_next[15:8], b};
                    default:
                    begin
                        if (b == 8'd0 || b > 8'(MAX_COMPONENTS))
                        begin
                            res0 = make_rec(ST_BAD_COUNT, prec_next, hgt_next, wid_next, b,
                                            mh_next, mv_next, 8'd0, 4'd0, 4'd0, 8'd0);
                            push_n      = 2'd1;
                            halted_next = 1'b1;
                            adv         = 1'b0;
                        end
                        else
                        begin
                            cnt_next = b[2:0];
                        end
                    end
                endcase
            end
            else
            begin
                unique case (phase_next)
                    2'd0:
                    begin
                        if (b > 8'(MAX_COMPONENTS))
                        begin
                            res0 = make_rec(ST_LARGE_ID, prec_next, hgt_next, wid_next,
                                            {5'd0, cnt_next}, mh_next, mv_next, b,
                                            4'd0, 4'd0, 8'd0);
                            push_n      = 2'd1;
                            halted_next = 1'b1;
                            adv         = 1'b0;
                        end
                        else
                        begin
                            id_next = b;
                        end
                    end
                    2'd1:
                    begin
                        if (!factor_ok(b[7:4]) || !factor_ok(b[3:0]))
                        begin
                            res0 = make_rec(factor_ok(b[7:4]) ? ST_BAD_V : ST_BAD_H,
                                            prec_next, hgt_next, wid_next,
                                            {5'd0, cnt_next}, mh_next, mv_next, id_next,
                                            b[7:4], b[3:0], 8'd0);
                            push_n      = 2'd1;
                            halted_next = 1'b1;
                            adv         = 1'b0;
                        end
                        else
                        begin
                            h_next = b[7:4];
                            v_next = b[3:0];
                        end
                    end
                    default:
                    begin
                        if (h_next > mh_next) mh_next = h_next;
                        if (v_next > mv_next) mv_next = v_next;
                        res0 = make_rec(ST_RECORD, prec_next, hgt_next, wid_next,
                                        {5'd0, cnt_next}, mh_next, mv_next, id_next,
                                        h_next, v_next, b);
                        push_n    = 2'd1;
                        done_next = done_inc;
                        if (done_inc == cnt_next)
                        begin
                            res1 = make_rec((len_next == expect_len) ? ST_FRAME_OK
                                                                     : ST_BAD_SIZE,
                                            prec_next, hgt_next, wid_next,
                                            {5'd0, cnt_next}, mh_next, mv_next,
                                            8'd0, 4'd0, 4'd0, 8'd0);
                            push_n      = 2'd2;
                            halted_next = 1'b1;
                            adv         = 1'b0;
                        end
                    end
                endcase
            end

            if (adv)
            begin
                if (pos_next >= 5'(FIXED_HDR_BYTES))
                begin
                    phase_next = (phase_next == 2'd2) ? 2'd0 : phase_next + 2'd1;
                end
                pos_next = pos_next + 5'd1;
                if (s_axis_tlast)
                begin
                    if (push_n == 2'd0)
                    begin
                        res0 = make_rec(ST_BAD_SIZE, prec_next, hgt_next, wid_next,
                                        {5'd0, cnt_next}, mh_next, mv_next,
                                        8'd0, 4'd0, 4'd0, 8'd0);
                    end
                    else
                    begin
                        res1 = make_rec(ST_BAD_SIZE, prec_next, hgt_next, wid_next,
                                        {5'd0, cnt_next}, mh_next, mv_next,
                                        8'd0, 4'd0, 4'd0, 8'd0);
                    end
                    push_n      = push_n + 2'd1;
                    halted_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= '0;
            len_reg    <= '0;
            prec_reg   <= '0;
            hgt_reg    <= '0;
            wid_reg    <= '0;
            cnt_reg    <= '0;
            done_reg   <= '0;
            id_reg     <= '0;
            h_reg      <= '0;
            v_reg      <= '0;
            mh_reg     <= '0;
            mv_reg     <= '0;
            halted_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            prec_reg   <= prec_next;
            hgt_reg    <= hgt_next;
            wid_reg    <= wid_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            id_reg     <= id_next;
            h_reg      <= h_next;
            v_reg      <= v_next;
            mh_reg     <= mh_next;
            mv_reg     <= mv_next;
            halted_reg <= halted_next;
        end
    end

    // output queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_reg + (in_fire ? (PTR_W+1)'(push_n) : '0)
                        - (out_fire ? (PTR_W+1)'(1) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (in_fire && push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    rec_t head;
    assign head         = fifo_mem[rd_ptr_reg];
    assign m_axis_tuser = head.status;
    assign m_axis_tdata = {head.quant_table, head.v_factor, head.h_factor,
                           head.component_id, head.max_v, head.max_h,
                           head.component_count, head.width, head.height,
                           head.precision};

endmodule

[test/tb_top.sv]
// Testbench for jpeg_frame_header_parser: frame header segments in, checked records out.
module tb_top
    import jfhp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COMPONENTS = 4;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_LIMIT   = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    jpeg_frame_header_parser #(
        .MAX_COMPONENTS(MAX_COMPONENTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #2 clk = ~clk;

    // parser state as the header bytes should leave it
    logic [4:0]  hdr_pos = '0;
    logic [15:0] hdr_len = '0;
    logic [7:0]  hdr_prec = '0;
    logic [15:0] hdr_height = '0;
    logic [15:0] hdr_width = '0;
    logic [2:0]  hdr_nf = '0;
    logic [2:0]  comps_seen = '0;
    logic [7:0]  comp_id = '0;
    logic [3:0]  comp_h = '0;
    logic [3:0]  comp_v = '0;
    logic [3:0]  peak_h = '0;
    logic [3:0]  peak_v = '0;
    logic        parser_idle = 1'b1;

    rec_t expected_records[$];
    int   parsed_items = 0;
    int   fail_count = 0;

    bit   tx_idle_on = 1'b0;
    bit   rx_idle_on = 1'b0;
    int   hold_ticket = 0;
    int   hold_seen = 0;
    int   rx_hold_left = 0;
    int   rx_gap_left = 0;

    logic out_fire = 1'b0;
    rec_t out_rec;

    function automatic int pick_gap();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [3:0] pick_factor();
        case ($urandom_range(0, 2))
            0: return 4'd1;
            1: return 4'd2;
            default: return 4'd4;
        endcase
    endfunction

    function automatic string rec_text(rec_t r);
        return $sformatf("%s prec=%h ht=%h wd=%h nf=%h mh=%h mv=%h id=%h h=%h v=%h q=%h",
                         r.status.name(), r.precision, r.height, r.width, r.component_count,
                         r.max_h, r.max_v, r.component_id, r.h_factor, r.v_factor,
                         r.quant_table);
    endfunction

    function automatic void queue_record(status_t st, logic [7:0] cnt, logic [7:0] id,
                                         logic [3:0] h, logic [3:0] v, logic [7:0] q);
        rec_t r;
        r.status          = st;
        r.precision       = hdr_prec;
        r.height          = hdr_height;
        r.width           = hdr_width;
        r.component_count = cnt;
        r.max_h           = peak_h;
        r.max_v           = peak_v;
        r.component_id    = id;
        r.h_factor        = h;
        r.v_factor        = v;
        r.quant_table     = q;
        expected_records.push_back(r);
    endfunction

    // Advance the parser by one header byte and queue the records it produces.
    function automatic void parse_header_byte(logic [7:0] b, logic st, logic en);
        logic [4:0] p;
        int         sub;
        logic [3:0] hn;
        logic [3:0] vn;
        bit         h_ok;
        bit         v_ok;
        if (st) begin
            hdr_pos = '0;
            hdr_len = '0;
            hdr_prec = '0;
            hdr_height = '0;
            hdr_width = '0;
            hdr_nf = '0;
            comps_seen = '0;
            comp_id = '0;
            comp_h = '0;
            comp_v = '0;
            peak_h = '0;
            peak_v = '0;
            parser_idle = 1'b0;
        end
        if (parser_idle)
            return;
        parsed_items++;
        p = hdr_pos;
        if (p < 5'd8) begin
            case (p)
                5'd0: hdr_len[15:8] = b;
                5'd1: hdr_len[7:0] = b;
                5'd2: hdr_prec = b;
                5'd3: hdr_height[15:8] = b;
                5'd4: hdr_height[7:0] = b;
                5'd5: hdr_width[15:8] = b;
                5'd6: hdr_width[7:0] = b;
                default:
                begin
                    if (b == 8'd0 || b > MAX_COMPONENTS) begin
                        queue_record(ST_BAD_COUNT, b, 8'd0, 4'd0, 4'd0, 8'd0);
                        parser_idle = 1'b1;
                        return;
                    end
                    hdr_nf = b[2:0];
                end
            endcase
        end
        else begin
            sub = (int'(p) - 8) % 3;
            if (sub == 0) begin
                if (b > MAX_COMPONENTS) begin
                    queue_record(ST_LARGE_ID, {5'd0, hdr_nf}, b, 4'd0, 4'd0, 8'd0);
                    parser_idle = 1'b1;
                    return;
                end
                comp_id = b;
            end
            else if (sub == 1) begin
                hn = b[7:4];
                vn = b[3:0];
                h_ok = hn inside {4'd1, 4'd2, 4'd4};
                v_ok = vn inside {4'd1, 4'd2, 4'd4};
                if (!h_ok || !v_ok) begin
                    // H is reported first when both are bad
                    queue_record(h_ok ? ST_BAD_V : ST_BAD_H, {5'd0, hdr_nf}, comp_id, hn, vn,
                                 8'd0);
                    parser_idle = 1'b1;
                    return;
                end
                comp_h = hn;
                comp_v = vn;
            end
            else begin
                if (comp_h > peak_h)
                    peak_h = comp_h;
                if (comp_v > peak_v)
                    peak_v = comp_v;
                queue_record(ST_RECORD, {5'd0, hdr_nf}, comp_id, comp_h, comp_v, b);
                comps_seen = comps_seen + 3'd1;
                if (comps_seen == hdr_nf) begin
                    queue_record((hdr_len == 16'(8 + 3 * hdr_nf)) ? ST_FRAME_OK : ST_BAD_SIZE,
                                 {5'd0, hdr_nf}, 8'd0, 4'd0, 4'd0, 8'd0);
                    parser_idle = 1'b1;
                    return;
                end
            end
        end
        hdr_pos = p + 5'd1;
        if (en) begin
            queue_record(ST_BAD_SIZE, {5'd0, hdr_nf}, 8'd0, 4'd0, 4'd0, 8'd0);
            parser_idle = 1'b1;
        end
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        s_axis_tlast  <= en;
        do
            @(negedge clk);
        while (s_axis_tready !== 1'b1);
        @(posedge clk);
        parse_header_byte(b, st, en);
    endtask

    task automatic send_header(input logic [15:0] len, input logic [7:0] prec,
                               input logic [15:0] ht, input logic [15:0] wd,
                               input logic [7:0] nf);
        send_byte(len[15:8], 1'b1, 1'b0);
        send_byte(len[7:0], 1'b0, 1'b0);
        send_byte(prec, 1'b0, 1'b0);
        send_byte(ht[15:8], 1'b0, 1'b0);
        send_byte(ht[7:0], 1'b0, 1'b0);
        send_byte(wd[15:8], 1'b0, 1'b0);
        send_byte(wd[7:0], 1'b0, 1'b0);
        send_byte(nf, 1'b0, 1'b0);
    endtask

    // One segment with random content; with faults set it may carry a bad count,
    // a random length, an early end, a restart or corrupted component bytes.
    task automatic send_random_segment(input bit faults);
        logic [7:0]  seg[$];
        logic [15:0] len;
        logic [7:0]  samp;
        int          kind;
        int          nf;
        int          ncomp;
        int          stop_at;
        kind = faults ? $urandom_range(0, 9) : 9;
        nf = $urandom_range(1, 4);
        if (kind == 0)
            nf = $urandom_range(0, 1) ? 0 : $urandom_range(5, 255);
        len = (kind == 1) ? 16'($urandom) : 16'(8 + 3 * nf);
        seg.push_back(len[15:8]);
        seg.push_back(len[7:0]);
        repeat (5) seg.push_back(8'($urandom));
        seg.push_back(8'(nf));
        ncomp = (nf >= 1 && nf <= 4) ? nf : 2;
        repeat (ncomp) begin
            if (kind == 4 && $urandom_range(0, 2) == 0)
                seg.push_back(8'($urandom_range(5, 255)));
            else
                seg.push_back(8'($urandom_range(0, 4)));
            samp = {pick_factor(), pick_factor()};
            if (kind == 4 && $urandom_range(0, 2) == 0)
                samp = 8'($urandom);
            seg.push_back(samp);
            seg.push_back(8'($urandom));
        end
        stop_at = (kind == 2 || kind == 3) ? $urandom_range(0, seg.size() - 1) : seg.size() - 1;
        for (int i = 0; i <= stop_at; i++)
            send_byte(seg[i], i == 0, i == stop_at && kind != 3);
        if (faults && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
    endtask

    task automatic test_complete_frame();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_byte(8'hFF, 1'b0, 1'b1);
        send_header(16'd11, 8'hFF, 16'hFFFF, 16'h0000, 8'd1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h44, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_field_errors();
        send_header(16'hFFFF, 8'h55, 16'h1234, 16'hABCD, 8'd4);
        send_byte(8'd4, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_header(16'd8, 8'h00, 16'h0000, 16'h0000, 8'd0);
    endtask

    task automatic test_restart_and_early_end();
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h0B, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h0B, 1'b0, 1'b0);
        send_byte(8'h08, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_ticket++;
        repeat (12) send_random_segment(1'b0);
    endtask

    task automatic test_random_segments();
        int start_count;
        int seg_no;
        start_count = parsed_items;
        seg_no = 0;
        while (parsed_items - start_count < RANDOM_ITEMS) begin
            tx_idle_on = (seg_no % 40) >= 8;
            rx_idle_on = (seg_no % 30) >= 5;
            send_random_segment(1'($urandom_range(0, 1)));
            seg_no++;
        end
    endtask

    always @(posedge clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rx_gap_left = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(negedge clk) begin
        out_fire <= rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1;
        out_rec  <= rec_t'({m_axis_tuser, m_axis_tdata});
    end

    always @(posedge clk) begin
        if (out_fire) begin
            if (expected_records.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected transfer: %s", rec_text(out_rec));
            end
            else begin
                if (out_rec.status !== expected_records[0].status ||
                    out_rec.precision !== expected_records[0].precision ||
                    out_rec.height !== expected_records[0].height ||
                    out_rec.width !== expected_records[0].width ||
                    out_rec.component_count !== expected_records[0].component_count ||
                    out_rec.max_h !== expected_records[0].max_h ||
                    out_rec.max_v !== expected_records[0].max_v ||
                    out_rec.component_id !== expected_records[0].component_id ||
                    out_rec.h_factor !== expected_records[0].h_factor ||
                    out_rec.v_factor !== expected_records[0].v_factor ||
                    out_rec.quant_table !== expected_records[0].quant_table) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  exp: %s", rec_text(expected_records[0]));
                        $display("  got: %s", rec_text(out_rec));
                    end
                end
                void'(expected_records.pop_front());
            end
        end
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_complete_frame();
        test_field_errors();
        test_restart_and_early_end();
        test_output_backpressure();
        test_random_segments();
        s_axis_tvalid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
